@@ rtl/bef_pkg.sv @@
`default_nettype none

package bef_pkg;

	localparam int DEF_MAX_BOXES  = 16;
	localparam int DEF_COORD_BITS = 16;
	localparam int DEF_DATA_BITS  = 8;

	localparam int SLOT_BITS     = 4;
	localparam int COUNT_BITS    = 5;
	localparam int CFG_IDX_BITS  = 1;
	localparam int CFG_DATA_BITS = 5;

	localparam logic [CFG_IDX_BITS-1:0] REG_BOX_COUNT      = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_SINGLE_CHANNEL = 1'd1;

	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_PIXEL = 1'b1;

	// Control word that travels with every item along the cell chain.
	typedef struct packed {
		logic valid;
		logic pixel;
		logic hit;
	} ctl_t;

endpackage

`default_nettype wire

@@ rtl/bef_cell.sv @@
`default_nettype none

module bef_cell #(
	parameter int CELL_IDX   = 0,
	parameter int COORD_BITS = 16,
	parameter int DATA_BITS  = 8
) (
	input  wire                               clk,
	input  wire                               arst_n,
	input  wire                               adv,
	input  wire                               check_en,
	input  bef_pkg::ctl_t                     in_ctl,
	input  wire  [bef_pkg::SLOT_BITS-1:0]     in_slot,
	input  wire  [COORD_BITS-1:0]             in_col,
	input  wire  [COORD_BITS-1:0]             in_row,
	input  wire  [COORD_BITS-1:0]             in_col_end,
	input  wire  [COORD_BITS-1:0]             in_row_end,
	input  wire  [DATA_BITS-1:0]              in_chan0,
	input  wire  [DATA_BITS-1:0]              in_chan1,
	input  wire  [DATA_BITS-1:0]              in_chan2,
	output bef_pkg::ctl_t                     out_ctl,
	output logic [bef_pkg::SLOT_BITS-1:0]     out_slot,
	output logic [COORD_BITS-1:0]             out_col,
	output logic [COORD_BITS-1:0]             out_row,
	output logic [COORD_BITS-1:0]             out_col_end,
	output logic [COORD_BITS-1:0]             out_row_end,
	output logic [DATA_BITS-1:0]              out_chan0,
	output logic [DATA_BITS-1:0]              out_chan1,
	output logic [DATA_BITS-1:0]              out_chan2
);
	import bef_pkg::*;

	logic [COORD_BITS-1:0] left_q, top_q, right_q, bottom_q;
	logic [DATA_BITS-1:0]  fill0_q, fill1_q, fill2_q;

	logic slot_match, load_here, in_box, take;
	ctl_t ctl_s1;
	logic [SLOT_BITS-1:0]  slot_s1;
	logic [COORD_BITS-1:0] col_s1, row_s1, col_end_s1, row_end_s1;
	logic [DATA_BITS-1:0]  chan0_s1, chan1_s1, chan2_s1;

	assign slot_match = (32'(in_slot) == 32'(CELL_IDX));
	assign load_here  = in_ctl.valid && !in_ctl.pixel && slot_match;
	assign in_box     = (in_col >= left_q) && (in_col < right_q) &&
	                    (in_row >= top_q) && (in_row < bottom_q);
	// The first matching box wins: a pixel already hit upstream keeps its fill.
	assign take       = in_ctl.valid && in_ctl.pixel && !in_ctl.hit && check_en && in_box;

	always_ff @(posedge clk) begin
		if (adv && load_here) begin
			left_q   <= in_col;
			top_q    <= in_row;
			right_q  <= in_col_end;
			bottom_q <= in_row_end;
			fill0_q  <= in_chan0;
			fill1_q  <= in_chan1;
			fill2_q  <= in_chan2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid <= in_ctl.valid;
			ctl_s1.pixel <= in_ctl.pixel;
			ctl_s1.hit   <= in_ctl.hit || take;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			slot_s1    <= in_slot;
			col_s1     <= in_col;
			row_s1     <= in_row;
			col_end_s1 <= in_col_end;
			row_end_s1 <= in_row_end;
			chan0_s1   <= take ? fill0_q : in_chan0;
			chan1_s1   <= take ? fill1_q : in_chan1;
			chan2_s1   <= take ? fill2_q : in_chan2;
		end
	end

	assign out_ctl     = ctl_s1;
	assign out_slot    = slot_s1;
	assign out_col     = col_s1;
	assign out_row     = row_s1;
	assign out_col_end = col_end_s1;
	assign out_row_end = row_end_s1;
	assign out_chan0   = chan0_s1;
	assign out_chan1   = chan1_s1;
	assign out_chan2   = chan2_s1;

endmodule

`default_nettype wire

@@ rtl/box_erase_fill_unit.sv @@
`default_nettype none

// Channel   Dir  Handshake          Contents
// s_axis    in   s_tvalid/s_tready  tuser: command; tdata: slot, bounds, channels
// m_axis    out  m_tvalid/m_tready  tuser: erased; tdata: three result channels
// cfg       in   cfg_we             cfg_index selects box_count or single_channel
//
// Every item walks a chain of MAX_BOXES box cells, then an output register;
// unless the output stalls, items move one cell and one item enters per cycle.
// Load items travel the chain too, so a box is updated in order with pixels.
// Reset clears control state and configuration; box contents are undefined
// until loaded. A stalled output freezes the whole chain.

module box_erase_fill_unit #(
	parameter int MAX_BOXES  = bef_pkg::DEF_MAX_BOXES,
	parameter int COORD_BITS = bef_pkg::DEF_COORD_BITS,
	parameter int DATA_BITS  = bef_pkg::DEF_DATA_BITS,
	localparam int IN_W  = ((bef_pkg::SLOT_BITS + 4*COORD_BITS + 3*DATA_BITS + 7) / 8) * 8,
	localparam int OUT_W = ((3*DATA_BITS + 7) / 8) * 8
) (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 s_tvalid,
	output logic                                s_tready,
	// box_slot, col, row, col_end, row_end, chan0, chan1, chan2 (low bit up)
	input  wire  [IN_W-1:0]                     s_tdata,
	// command
	input  wire                                 s_tuser,
	output logic                                m_tvalid,
	input  wire                                 m_tready,
	// out_chan0, out_chan1, out_chan2 (low bit up)
	output logic [OUT_W-1:0]                    m_tdata,
	// erased
	output logic                                m_tuser,
	input  wire                                 cfg_we,
	input  wire  [bef_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire  [bef_pkg::CFG_DATA_BITS-1:0]   cfg_data
);
	import bef_pkg::*;

	localparam int CB = COORD_BITS;
	localparam int DB = DATA_BITS;

	logic [COUNT_BITS-1:0] box_count_q;
	logic                  single_q;

	logic adv;

	ctl_t                  c_ctl     [MAX_BOXES+1];
	logic [SLOT_BITS-1:0]  c_slot    [MAX_BOXES+1];
	logic [CB-1:0]         c_col     [MAX_BOXES+1];
	logic [CB-1:0]         c_row     [MAX_BOXES+1];
	logic [CB-1:0]         c_col_end [MAX_BOXES+1];
	logic [CB-1:0]         c_row_end [MAX_BOXES+1];
	logic [DB-1:0]         c_chan0   [MAX_BOXES+1];
	logic [DB-1:0]         c_chan1   [MAX_BOXES+1];
	logic [DB-1:0]         c_chan2   [MAX_BOXES+1];

	logic          out_valid_q, erased_q;
	logic [DB-1:0] o_chan0_q, o_chan1_q, o_chan2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_count_q <= '0;
			single_q    <= 1'b0;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_BOX_COUNT:      box_count_q <= cfg_data[COUNT_BITS-1:0];
				REG_SINGLE_CHANNEL: single_q    <= cfg_data[0];
				default:            ;
			endcase
		end
	end

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;

	assign c_ctl[0].valid = s_tvalid;
	assign c_ctl[0].pixel = (s_tuser == CMD_PIXEL);
	assign c_ctl[0].hit   = 1'b0;
	assign c_slot[0]      = s_tdata[SLOT_BITS-1:0];
	assign c_col[0]       = s_tdata[SLOT_BITS +: CB];
	assign c_row[0]       = s_tdata[SLOT_BITS + CB +: CB];
	assign c_col_end[0]   = s_tdata[SLOT_BITS + 2*CB +: CB];
	assign c_row_end[0]   = s_tdata[SLOT_BITS + 3*CB +: CB];
	assign c_chan0[0]     = s_tdata[SLOT_BITS + 4*CB +: DB];
	assign c_chan1[0]     = s_tdata[SLOT_BITS + 4*CB + DB +: DB];
	assign c_chan2[0]     = s_tdata[SLOT_BITS + 4*CB + 2*DB +: DB];

	for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
		logic check_en;

		// Counts above MAX_BOXES simply enable every cell.
		assign check_en = (32'(box_count_q) > 32'(i));

		bef_cell #(
			.CELL_IDX   (i),
			.COORD_BITS (CB),
			.DATA_BITS  (DB)
		) u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.adv         (adv),
			.check_en    (check_en),
			.in_ctl      (c_ctl[i]),
			.in_slot     (c_slot[i]),
			.in_col      (c_col[i]),
			.in_row      (c_row[i]),
			.in_col_end  (c_col_end[i]),
			.in_row_end  (c_row_end[i]),
			.in_chan0    (c_chan0[i]),
			.in_chan1    (c_chan1[i]),
			.in_chan2    (c_chan2[i]),
			.out_ctl     (c_ctl[i+1]),
			.out_slot    (c_slot[i+1]),
			.out_col     (c_col[i+1]),
			.out_row     (c_row[i+1]),
			.out_col_end (c_col_end[i+1]),
			.out_row_end (c_row_end[i+1]),
			.out_chan0   (c_chan0[i+1]),
			.out_chan1   (c_chan1[i+1]),
			.out_chan2   (c_chan2[i+1])
		);
	end

	// Only pixel items leave the chain as results; load items end here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= c_ctl[MAX_BOXES].valid && c_ctl[MAX_BOXES].pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			erased_q  <= c_ctl[MAX_BOXES].hit;
			o_chan0_q <= c_chan0[MAX_BOXES];
			o_chan1_q <= single_q ? '0 : c_chan1[MAX_BOXES];
			o_chan2_q <= single_q ? '0 : c_chan2[MAX_BOXES];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = erased_q;
	assign m_tdata  = OUT_W'({o_chan2_q, o_chan1_q, o_chan0_q});

	a_pixel_reaches_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && c_ctl[MAX_BOXES].valid && c_ctl[MAX_BOXES].pixel |=> m_tvalid)
		else $error("pixel leaving the chain was dropped");

	a_no_phantom_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv && !(c_ctl[MAX_BOXES].valid && c_ctl[MAX_BOXES].pixel) |=> !m_tvalid)
		else $error("result produced without a pixel item");

	a_hit_only_pixel: assert property (@(posedge clk) disable iff (!arst_n)
		c_ctl[MAX_BOXES].valid && c_ctl[MAX_BOXES].hit |-> c_ctl[MAX_BOXES].pixel)
		else $error("load item marked as a box hit");

endmodule

`default_nettype wire
